// File: design/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the stable priority or FIFO queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH = 16;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int OCC_W = 5;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_PRIO = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic signed [7:0] prio;
    logic [15:0]       handle;
  } entry_t;

  localparam int EW = $bits(entry_t);

endpackage

// File: design/spq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that updates only when the read enable is high.
// ----------------------------------------------------------------------------
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/stable_priority_or_fifo_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_or_fifo_queue
// Bounded queue of handle and priority pairs in a ring buffer held in RAM,
// with FIFO order or stable priority order.
// ----------------------------------------------------------------------------
//  channel  direction  tdata (low bit up)                 tuser (low bit up)
//  in_      slave      handle[15:0] prio[23:16]           op
//  out_     master     handle[15:0] prio[23:16] occ[28:24] popped_valid status[2:1]
//  cfg_     write      ordering_mode                      -
//
// A pop goes from idle straight to the finish state and a FIFO push passes
// through the tail write; a priority push into a non-empty queue first walks
// the entries from the head, reading and rewriting one RAM entry per cycle.
// Reset clears the count, the head pointer, the mode and the output valid flag.
// A finished item waits in the output register while the next item is taken.
module stable_priority_or_fifo_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // message_handle, priority_req
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // popped_handle, popped_priority, occupancy
  output logic [2:0]  out_tuser   // popped_valid, status
);
  import spq_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_WALK, S_TAIL, S_FIN} state_t;

  state_t           state_r, state_nxt;
  logic             mode_r, mode_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [AW-1:0]    head_r, head_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic             vd_r, vd_nxt;
  logic             ins_r, ins_nxt;
  entry_t           carry_r, carry_nxt;
  entry_t           new_r, new_nxt;
  logic [1:0]       status_r, status_nxt;
  logic             pop_ok_r, pop_ok_nxt;
  logic             push_ok_r, push_ok_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_pv_r, out_pv_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  entry_t           out_entry_r, out_entry_nxt;
  logic [OCC_W-1:0] out_occ_r, out_occ_nxt;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  entry_t           ram_wdata, ram_rdata;
  logic             accept, slot_free;

  function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] head,
                                              input logic [CW-1:0] idx);
    logic [CW:0] sum;
    sum = (CW+1)'(head) + (CW+1)'(idx);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return AW'(sum);
  endfunction

  spq_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = cfg_we ? cfg_wdata : mode_r;
    count_nxt      = count_r;
    head_nxt       = head_r;
    idx_nxt        = idx_r;
    vd_nxt         = vd_r;
    ins_nxt        = ins_r;
    carry_nxt      = carry_r;
    new_nxt        = new_r;
    status_nxt     = status_r;
    pop_ok_nxt     = pop_ok_r;
    push_ok_nxt    = push_ok_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_pv_nxt     = out_pv_r;
    out_status_nxt = out_status_r;
    out_entry_nxt  = out_entry_r;
    out_occ_nxt    = out_occ_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = ring_addr(head_r, count_r);
    ram_raddr      = head_r;
    ram_wdata      = new_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          new_nxt.handle = in_tdata[15:0];
          new_nxt.prio   = in_tdata[23:16];
          status_nxt     = ST_OK;
          pop_ok_nxt     = 1'b0;
          push_ok_nxt    = 1'b0;
          ins_nxt        = 1'b0;
          idx_nxt        = '0;
          vd_nxt         = 1'b0;
          state_nxt      = S_FIN;
          if (in_tuser == OP_POP) begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              ram_re     = 1'b1;
              pop_ok_nxt = 1'b1;
            end
          end else begin
            if (count_r == CW'(DEPTH)) begin
              status_nxt = ST_FULL;
            end else begin
              push_ok_nxt = 1'b1;
              if (mode_r == MODE_PRIO && count_r != '0) begin
                state_nxt = S_WALK;
              end else begin
                state_nxt = S_TAIL;
              end
            end
          end
        end
      end
      S_WALK: begin
        ram_waddr = ring_addr(head_r, idx_r - CW'(1));
        if (vd_r) begin
          if (ins_r) begin
            ram_we    = 1'b1;
            ram_wdata = carry_r;
            carry_nxt = ram_rdata;
          end else if (ram_rdata.prio < new_r.prio) begin
            ram_we    = 1'b1;
            ram_wdata = new_r;
            carry_nxt = ram_rdata;
            ins_nxt   = 1'b1;
          end
        end
        if (idx_r < count_r) begin
          ram_re    = 1'b1;
          ram_raddr = ring_addr(head_r, idx_r);
          idx_nxt   = idx_r + CW'(1);
          vd_nxt    = 1'b1;
        end else begin
          vd_nxt    = 1'b0;
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        ram_we    = 1'b1;
        ram_waddr = ring_addr(head_r, count_r);
        ram_wdata = ins_r ? carry_r : new_r;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          if (push_ok_r) begin
            count_nxt = count_r + CW'(1);
          end else if (pop_ok_r) begin
            count_nxt = count_r - CW'(1);
            head_nxt  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
          end
          out_valid_nxt  = 1'b1;
          out_pv_nxt     = pop_ok_r;
          out_status_nxt = status_r;
          out_entry_nxt  = pop_ok_r ? ram_rdata : '0;
          out_occ_nxt    = OCC_W'(count_nxt);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_FIFO;
      count_r     <= '0;
      head_r      <= '0;
      idx_r       <= '0;
      vd_r        <= 1'b0;
      ins_r       <= 1'b0;
      status_r    <= ST_OK;
      pop_ok_r    <= 1'b0;
      push_ok_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      idx_r       <= idx_nxt;
      vd_r        <= vd_nxt;
      ins_r       <= ins_nxt;
      status_r    <= status_nxt;
      pop_ok_r    <= pop_ok_nxt;
      push_ok_r   <= push_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
    carry_r      <= carry_nxt;
    new_r        <= new_nxt;
    out_pv_r     <= out_pv_nxt;
    out_status_r <= out_status_nxt;
    out_entry_r  <= out_entry_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_occ_r, out_entry_r.prio, out_entry_r.handle};
  assign out_tuser  = {out_status_r, out_pv_r};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> idx_r <= count_r && count_r != '0)
    else $error("walk index beyond stored entries");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE || state_r == S_FIN |-> !ram_we)
    else $error("RAM written outside a push");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && slot_free && pop_ok_r |=> count_r == $past(count_r) - CW'(1))
    else $error("pop did not remove one entry");

  a_result_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_pv_r |-> out_status_r == ST_OK)
    else $error("popped entry reported with error status");

endmodule
